@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SKT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted key table check failed");

// Next-cycle implication checked on every clock edge outside reset.
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

// Next-cycle implication that also holds through reset.
`define SKT_ASSERT_NEXT_NORST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

`endif

@@ sv/skt_pkg.sv @@
// Shared types and codes for the sorted key table.
// No dependencies.
`default_nettype none

package skt_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_EVAL,
    S_SHU_RD,
    S_SHU_WR,
    S_WKEY,
    S_SHD_RD,
    S_SHD_WR,
    S_DONE
  } state_t;

  // Result of the shared key compare: probe key against stored entry.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ sv/sorted_key_table_core.sv @@
// Sorted key table: sequencer, search and shift control, result register.
// Depends on skt_pkg, skt_store and skt_cmp.
//
// Usage: the in_ channel carries one operation (op, key, insert_if_missing)
// with valid/ready; the out_ channel returns one result per operation with
// valid/ready. cfg_we writes cfg_wdata into the order select (0 unsigned,
// 1 signed); write it only while the block is idle.
// One operation is handled at a time; in_ready is high only when the
// sequencer is idle. Each binary search probe is a store read (S_SRCH),
// then a compare (S_CMP), at most $clog2(DEPTH+1) probes. Moving entries
// for an insert or remove passes each moved entry through a read state
// (S_SHU_RD or S_SHD_RD) and then a write state (S_SHU_WR or S_SHD_WR).
// Reset empties the table (count 0), selects unsigned order and drops any
// pending result. Store contents need no clearing: entries at or above the
// count are never read. A result waits in the output register while
// out_ready is low; the block may already accept the next item, and it
// holds its next result until the register frees.
`default_nettype none

module sorted_key_table_core #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_op,
  input  wire logic [KEY_WIDTH-1:0]       in_key,
  input  wire logic                       in_insert_if_missing,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_found,
  output logic                            out_inserted,
  output logic [$clog2(DEPTH)-1:0]        out_position,
  output logic [1:0]                      out_status,
  output logic [$clog2(DEPTH+1)-1:0]      out_entry_count
);
  import skt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state_r, state_nxt;

  logic                 signed_order_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 ins_r, ins_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hip1_r, hip1_nxt;   // search upper bound plus one
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        at_r, at_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic                 found_r, found_nxt;
  logic                 inserted_r, inserted_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  status_t              status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_inserted_r, out_inserted_nxt;
  logic [AW-1:0]        out_pos_r, out_pos_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;
  cmp_res_t             cmp;

  logic [CW:0]          mid_sum;
  logic [AW-1:0]        mid;

  skt_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skt_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .probe        (key_r),
    .entry        (mem_rdata),
    .signed_order (signed_order_r),
    .res          (cmp)
  );

  // lo <= hi holds whenever mid is used, so the sum is never negative
  assign mid_sum = {1'b0, lo_r} + {1'b0, hip1_r} - (CW+1)'(1);
  assign mid     = mid_sum[AW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      signed_order_r <= 1'b0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        signed_order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    key_r          <= key_nxt;
    ins_r          <= ins_nxt;
    lo_r           <= lo_nxt;
    hip1_r         <= hip1_nxt;
    mid_r          <= mid_nxt;
    at_r           <= at_nxt;
    ptr_r          <= ptr_nxt;
    found_r        <= found_nxt;
    inserted_r     <= inserted_nxt;
    pos_r          <= pos_nxt;
    status_r       <= status_nxt;
    out_found_r    <= out_found_nxt;
    out_inserted_r <= out_inserted_nxt;
    out_pos_r      <= out_pos_nxt;
    out_status_r   <= out_status_nxt;
    out_count_r    <= out_count_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    op_nxt           = op_r;
    key_nxt          = key_r;
    ins_nxt          = ins_r;
    lo_nxt           = lo_r;
    hip1_nxt         = hip1_r;
    mid_nxt          = mid_r;
    at_nxt           = at_r;
    ptr_nxt          = ptr_r;
    found_nxt        = found_r;
    inserted_nxt     = inserted_r;
    pos_nxt          = pos_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_inserted_nxt = out_inserted_r;
    out_pos_nxt      = out_pos_r;
    out_status_nxt   = out_status_r;
    out_count_nxt    = out_count_r;
    mem_we           = 1'b0;
    mem_waddr        = ptr_r[AW-1:0];
    mem_wdata        = mem_rdata;
    mem_raddr        = mid;
    in_ready         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt       = in_op;
          key_nxt      = in_key;
          ins_nxt      = in_insert_if_missing;
          lo_nxt       = '0;
          hip1_nxt     = count_r;
          found_nxt    = 1'b0;
          inserted_nxt = 1'b0;
          pos_nxt      = '0;
          status_nxt   = ST_OK;
          state_nxt    = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hip1_r) begin
          mem_raddr = mid;
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          // miss: lo is the sorted insertion place
          at_nxt    = lo_r;
          found_nxt = 1'b0;
          state_nxt = S_EVAL;
        end
      end
      S_CMP: begin
        if (cmp.eq) begin
          at_nxt    = CW'(mid_r);
          found_nxt = 1'b1;
          state_nxt = S_EVAL;
        end else begin
          if (cmp.gt) begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end else begin
            hip1_nxt = CW'(mid_r);
          end
          state_nxt = S_SRCH;
        end
      end
      S_EVAL: begin
        if (op_r == OP_LOOKUP) begin
          if (found_r) begin
            pos_nxt   = at_r[AW-1:0];
            state_nxt = S_DONE;
          end else if (ins_r) begin
            if (count_r >= DEPTH_C) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              ptr_nxt   = count_r;
              state_nxt = S_SHU_RD;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          if (found_r) begin
            ptr_nxt   = at_r + CW'(1);
            state_nxt = S_SHD_RD;
          end else begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SHU_RD: begin
        // ptr is the destination; the source sits one below
        if (ptr_r > at_r) begin
          mem_raddr = AW'(ptr_r - CW'(1));
          state_nxt = S_SHU_WR;
        end else begin
          state_nxt = S_WKEY;
        end
      end
      S_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr_r - CW'(1);
        state_nxt = S_SHU_RD;
      end
      S_WKEY: begin
        mem_we       = 1'b1;
        mem_waddr    = at_r[AW-1:0];
        mem_wdata    = key_r;
        count_nxt    = count_r + CW'(1);
        inserted_nxt = 1'b1;
        pos_nxt      = at_r[AW-1:0];
        state_nxt    = S_DONE;
      end
      S_SHD_RD: begin
        // ptr is the source; the destination sits one below
        if (ptr_r < count_r) begin
          mem_raddr = ptr_r[AW-1:0];
          state_nxt = S_SHD_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          pos_nxt   = at_r[AW-1:0];
          state_nxt = S_DONE;
        end
      end
      S_SHD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r - CW'(1));
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr_r + CW'(1);
        state_nxt = S_SHD_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = found_r;
          out_inserted_nxt = inserted_r;
          out_pos_nxt      = pos_r;
          out_status_nxt   = status_r;
          out_count_nxt    = count_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_inserted    = out_inserted_r;
  assign out_position    = out_pos_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

@@ sv/skt_store.sv @@
// Key storage: single write port, single registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module skt_store #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [KEY_WIDTH-1:0]     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [KEY_WIDTH-1:0]     rdata
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/skt_cmp.sv @@
// Shared key compare unit, unsigned or two's complement order.
// Depends on skt_pkg for the result struct.
`default_nettype none

module skt_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic [KEY_WIDTH-1:0] probe,
  input  wire logic [KEY_WIDTH-1:0] entry,
  input  wire logic                 signed_order,
  output skt_pkg::cmp_res_t         res
);
  import skt_pkg::*;

  localparam logic [KEY_WIDTH-1:0] TOP = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  logic [KEY_WIDTH-1:0] pv;
  logic [KEY_WIDTH-1:0] ev;

  // flipping the sign bit maps signed order onto unsigned order
  assign pv = probe ^ (signed_order ? TOP : '0);
  assign ev = entry ^ (signed_order ? TOP : '0);

  always_comb begin
    res.eq = (pv == ev);
    res.gt = (pv > ev);
  end

endmodule

`default_nettype wire

@@ sv/skt_checker.sv @@
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module skt_checker #(
  parameter int DEPTH = 64
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_found,
  input wire logic                       out_inserted,
  input wire logic [$clog2(DEPTH)-1:0]   out_position,
  input wire logic [1:0]                 out_status,
  input wire logic [$clog2(DEPTH+1)-1:0] out_entry_count
);
  import skt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // an error result never reports a hit, an insert or a position
  `SKT_ASSERT_IMPL(a_err_clean, out_valid && (out_status != ST_OK), !out_found && !out_inserted && (out_position == '0))

  // an insert is never also a hit
  `SKT_ASSERT_IMPL(a_ins_not_found, out_valid && out_inserted, !out_found && (out_status == ST_OK))

  // the count never passes the table depth
  `SKT_ASSERT_IMPL(a_count_bound, out_valid, out_entry_count <= CW'(DEPTH))

  // a stalled result holds
  `SKT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry_count) && $stable(out_status))

  // reset drops any pending result
  `SKT_ASSERT_NEXT_NORST(a_rst_clear, !rst_n, !out_valid)

endmodule

bind sorted_key_table_core skt_checker #(.DEPTH(DEPTH)) u_skt_checker (.*);

`default_nettype wire
